// ----- rtl/utf8_stream_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared assertion forms for the decoder checker. They expect aclk and
// aresetn to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define U8DEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("u8dec check failed");

// Next-cycle implication, checked during reset as well.
`define U8DEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("u8dec check failed");

`endif

// ----- rtl/u8dec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Byte classes, queue item type and shared widths for the decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int CONT_BITS   = 6;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
    } item_t;

    // Class of a byte taken as a lead byte; continuation use is decided later.
    function automatic kind_t classify(input logic [BYTE_W-1:0] b);
        kind_t k;
        priority if (b[7] == 1'b0)        k = KIND_ASCII;
        else if (b[7:6] == 2'b10)         k = KIND_CONT;
        else if (b[7:5] == 3'b110)        k = KIND_LEAD2;
        else if (b[7:4] == 4'b1110)       k = KIND_LEAD3;
        else if (b[7:3] == 5'b11110)      k = KIND_LEAD4;
        else                              k = KIND_BAD;
        return k;
    endfunction

endpackage

// ----- rtl/u8dec_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder front stage
// Accepts input bytes, classifies them and registers them for the queue.
// ----------------------------------------------------------------------------
module u8dec_front
    import u8dec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_IN_W-1:0] s_tdata,   // [7:0] in_byte
    output logic                  push_valid,
    input  logic                  push_ready,
    output item_t                 push_item
);

    logic  valid_reg;
    item_t item_reg;

    // Take a new byte whenever the stage is empty or drains this cycle.
    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind <= classify(s_tdata[BYTE_W-1:0]);
            item_reg.data <= s_tdata[BYTE_W-1:0];
        end
    end

endmodule

// ----- rtl/u8dec_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder item queue
// Short flop-based FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module u8dec_queue
    import u8dec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT  // power of two, at least 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/u8dec_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder back stage
// Tracks the open sequence, assembles code points and holds the result.
// ----------------------------------------------------------------------------
module u8dec_back
    import u8dec_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  item_t                  pop_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,  // [20:0] code_point, rest zero
    output logic                   m_tuser   // [0] bad_lead
);

    logic [1:0]      owed_reg,     owed_next;
    logic [CP_W-1:0] partial_reg,  partial_next;
    logic            m_valid_reg,  m_valid_next;
    logic [CP_W-1:0] cp_reg,       cp_next;
    logic            bad_reg,      bad_next;
    logic            take;
    logic            emit;
    logic [CP_W-1:0] shifted;

    assign pop_ready = !m_valid_reg || m_tready;
    assign take      = pop_valid && pop_ready;
    assign shifted   = {partial_reg[CP_W-CONT_BITS-1:0], pop_item.data[CONT_BITS-1:0]};

    always_comb begin
        owed_next    = owed_reg;
        partial_next = partial_reg;
        emit         = 1'b0;
        cp_next      = cp_reg;
        bad_next     = bad_reg;
        if (take) begin
            if (owed_reg != 2'd0) begin
                // Any byte inside a sequence counts as a continuation.
                owed_next    = owed_reg - 2'd1;
                partial_next = shifted;
                if (owed_reg == 2'd1) begin
                    emit         = 1'b1;
                    cp_next      = shifted;
                    bad_next     = 1'b0;
                    partial_next = '0;
                end
            end else begin
                unique case (pop_item.kind)
                    KIND_ASCII: begin
                        emit     = 1'b1;
                        cp_next  = CP_W'(pop_item.data);
                        bad_next = 1'b0;
                    end
                    KIND_LEAD2: begin
                        owed_next    = 2'd1;
                        partial_next = CP_W'(pop_item.data[4:0]);
                    end
                    KIND_LEAD3: begin
                        owed_next    = 2'd2;
                        partial_next = CP_W'(pop_item.data[3:0]);
                    end
                    KIND_LEAD4: begin
                        owed_next    = 2'd3;
                        partial_next = CP_W'(pop_item.data[2:0]);
                    end
                    default: begin
                        // Stray continuation or 11111xxx: report and drop.
                        emit     = 1'b1;
                        cp_next  = '0;
                        bad_next = 1'b1;
                    end
                endcase
            end
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg    <= 2'd0;
            partial_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            owed_reg    <= owed_next;
            partial_reg <= partial_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            cp_reg  <= cp_next;
            bad_reg <= bad_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(cp_reg);
    assign m_tuser  = bad_reg;

endmodule

// ----- rtl/utf8_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Decodes a stream of UTF-8 bytes into 21-bit code points.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle, sustained while m_tready is held
// high, and each completed sequence yields one code point; an invalid
// lead byte (10xxxxxx or 11111xxx) yields one result with bad_lead set and
// a zero code point. Continuation bytes are not checked, and overlong
// forms and surrogates pass through. A byte is classified in the front
// register, waits in a QUEUE_DEPTH-entry FIFO and is folded into the open
// sequence by the back stage, which holds each result in its output
// register. While a result waits for m_tready the back stage holds, and
// the front register and the FIFO take up to QUEUE_DEPTH + 1 further
// bytes before s_tready drops.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core
    import u8dec_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT  // power of two, at least 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic                   m_tuser    // [0] bad_lead
);

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    u8dec_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    u8dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    u8dec_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- rtl/utf8_stream_decoder_core_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder port checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core_chk
    import u8dec_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic                   m_tuser
);

    // An error result carries no code point bits.
    `U8DEC_ASSERT_NOW(a_bad_zero_cp, m_tvalid && m_tuser, m_tdata[CP_W-1:0] == '0)
    // Padding above the code point stays zero.
    `U8DEC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[TDATA_OUT_W-1:CP_W] == '0)
    // A held result keeps its value until taken.
    `U8DEC_ASSERT_NEXT(a_hold, aresetn && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // After a reset edge nothing is offered and the input is open.
    `U8DEC_ASSERT_NEXT(a_reset_idle, !aresetn, !m_tvalid && s_tready)

endmodule

bind utf8_stream_decoder_core utf8_stream_decoder_core_chk u_chk (.*);

// ----- tb/sv/utf8_stream_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core testbench
// Streams UTF-8 bytes into the decoder and checks each code point it emits
// against a cycle-free decoder kept in the bench. Mostly well-formed
// sequences, plus invalid lead bytes, mangled sequences and raw noise,
// under random idle cycles on both sides and one long output stall.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_tb;
    import u8dec_pkg::*;

    localparam int BYTE_TARGET  = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT_BYTE = 250;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [7:0]  b;
        int unsigned gap_max;
        bit          drain_first;
    } stream_byte_t;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            bad_lead;
    } code_point_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;   // [7:0] in_byte
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;   // [20:0] code_point, [23:21] zero
    logic                   m_tuser;   // [0] bad_lead

    stream_byte_t byte_queue[$];
    code_point_t  cp_expected[$];

    // decoder state mirrored in the bench
    logic [1:0]      seq_owed;
    logic [CP_W-1:0] seq_bits;

    int unsigned n_pushed;
    int unsigned bytes_taken;
    int unsigned results_seen;
    int unsigned cycle_count;
    int unsigned err_count;
    bit          in_taken;
    bit          out_taken;
    bit          offering;
    bit          gap_drawn;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;

    utf8_stream_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic kind_t lead_kind(input logic [7:0] b);
        casez (b)
            8'b0???????: return KIND_ASCII;
            8'b10??????: return KIND_CONT;
            8'b110?????: return KIND_LEAD2;
            8'b1110????: return KIND_LEAD3;
            8'b11110???: return KIND_LEAD4;
            default:     return KIND_BAD;
        endcase
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        code_point_t d;
        d.cp       = '0;
        d.bad_lead = 1'b0;
        if (seq_owed != 2'd0) begin
            // any byte counts as a continuation here
            seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
            seq_owed = seq_owed - 2'd1;
            if (seq_owed == 2'd0) begin
                d.cp = seq_bits;
                cp_expected.push_back(d);
                seq_bits = '0;
            end
        end else begin
            case (lead_kind(b))
                KIND_ASCII: begin
                    d.cp = CP_W'(b);
                    cp_expected.push_back(d);
                end
                KIND_LEAD2: begin
                    seq_bits = CP_W'(b[4:0]);
                    seq_owed = 2'd1;
                end
                KIND_LEAD3: begin
                    seq_bits = CP_W'(b[3:0]);
                    seq_owed = 2'd2;
                end
                KIND_LEAD4: begin
                    seq_bits = CP_W'(b[2:0]);
                    seq_owed = 2'd3;
                end
                default: begin
                    d.bad_lead = 1'b1;
                    cp_expected.push_back(d);
                end
            endcase
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_byte_t t;
        t.b = b;
        // alternate slow, back-to-back and lightly idled stretches
        case ((n_pushed / 60) % 3)
            0:       t.gap_max = 10;
            1:       t.gap_max = 0;
            default: t.gap_max = 3;
        endcase
        t.drain_first = (n_pushed == 26 || n_pushed == 400);
        byte_queue.push_back(t);
        n_pushed++;
    endtask

    // one character of the given length; mangle fills the tail with raw bytes
    task automatic push_seq(input int unsigned len, input bit mangle);
        logic [7:0] b;
        case (len)
            1:       b = {1'b0, 7'($urandom)};
            2:       b = {3'b110, 5'($urandom)};
            3:       b = {4'b1110, 4'($urandom)};
            default: b = {5'b11110, 3'($urandom)};
        endcase
        push_byte(b);
        for (int i = 1; i < len; i++) begin
            b = mangle ? 8'($urandom) : {2'b10, 6'($urandom)};
            push_byte(b);
        end
    endtask

    // sample both channels and keep the expected code points
    always @(posedge aclk) begin
        code_point_t want;
        cycle_count++;
        in_taken  = aresetn && s_tvalid && s_tready;
        out_taken = aresetn && m_tvalid && m_tready;
        if (in_taken) begin
            decode_byte(s_tdata[7:0]);
            bytes_taken++;
        end
        if (out_taken) begin
            results_seen++;
            if (cp_expected.size() == 0) begin
                $error("unexpected result: code_point=%0h bad_lead=%0b",
                       m_tdata[CP_W-1:0], m_tuser);
                err_count++;
            end else begin
                want = cp_expected.pop_front();
                if (m_tdata[CP_W-1:0] !== want.cp) begin
                    $error("code_point: expected %0h, got %0h", want.cp, m_tdata[CP_W-1:0]);
                    err_count++;
                end
                if (m_tuser !== want.bad_lead) begin
                    $error("bad_lead: expected %0b, got %0b", want.bad_lead, m_tuser);
                    err_count++;
                end
            end
        end
    end

    // byte sender
    always @(negedge aclk) begin
        if (aresetn) begin
            if (offering && in_taken) begin
                offering  = 1'b0;
                gap_drawn = 1'b0;
            end
            if (!offering && byte_queue.size() > 0) begin
                if (!gap_drawn) begin
                    gap_left  = $urandom_range(0, byte_queue[0].gap_max);
                    gap_drawn = 1'b1;
                end
                if (byte_queue[0].drain_first && cp_expected.size() != 0) begin
                    // hold until every pending code point is out
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    s_tdata  <= byte_queue[0].b;
                    offering  = 1'b1;
                    void'(byte_queue.pop_front());
                end
            end
        end
        s_tvalid <= offering;
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                case ((results_seen / 50) % 3)
                    0:       stall_left = $urandom_range(0, 10);
                    1:       stall_left = 0;
                    default: stall_left = $urandom_range(0, 4);
                endcase
            end
            if (!hold_done && bytes_taken >= HOLD_AT_BYTE) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("utf8_stream_decoder_core_tb NOT OK");
        $finish;
    end

    initial begin
        int unsigned pick;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        seq_owed = '0;
        seq_bits = '0;

        // ASCII extremes, invalid leads
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'hBF);
        push_byte(8'hF8);
        push_byte(8'hFF);
        // each sequence length at its lowest and highest payload
        push_byte(8'hC0); push_byte(8'h80);
        push_byte(8'hDF); push_byte(8'hBF);
        push_byte(8'hE0); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBF);
        push_byte(8'hF0); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hF7); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
        // continuation that is really an ASCII byte
        push_byte(8'hC3); push_byte(8'h41);

        while (n_pushed < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                push_seq($urandom_range(1, 4), 1'b0);
            else if (pick < 85)
                push_byte(8'($urandom));
            else
                push_seq($urandom_range(2, 4), 1'b1);
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (byte_queue.size() == 0 && !offering);
        wait (cp_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("utf8_stream_decoder_core_tb OK");
        else
            $display("utf8_stream_decoder_core_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/u8dec_pkg.sv
rtl/u8dec_front.sv
rtl/u8dec_queue.sv
rtl/u8dec_back.sv
rtl/utf8_stream_decoder_core.sv
rtl/utf8_stream_decoder_core_chk.sv
tb/sv/utf8_stream_decoder_core_tb.sv
